>>> hdl/cst_pkg.sv
`default_nettype none

package cst_pkg;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;
   localparam int CNT_BITS       = 7;
   localparam int STATUS_BITS    = 3;
   localparam int CLOSE_ID_BITS  = 32;
   localparam int OPENED_ID_BITS = 32;
   localparam int MAX_SCAN       = 128;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SLOTS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLED   = 1'd1;

   localparam logic OP_OPEN  = 1'b0;
   localparam logic OP_CLOSE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_ENABLED = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL        = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_ID     = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND   = 3'd4;

   typedef struct packed {
      logic                     op;
      logic [CLOSE_ID_BITS-1:0] close_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]    status;
      logic [OPENED_ID_BITS-1:0] opened_id;
      logic [CNT_BITS-1:0]       active_count;
   } rsp_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] max_slots;
      logic                enabled;
   } cfg_type;

endpackage

`default_nettype wire

>>> hdl/cst_csr.sv
`default_nettype none

module cst_csr
   import cst_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                        cfg
);

   localparam logic [CNT_BITS-1:0] MAX_SLOTS_RST = CNT_BITS'((SLOTS < 64) ? SLOTS : 64);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    slots_ok;

   assign slots_ok = (csr_wdata != '0) && (32'(csr_wdata) <= 32'(SLOTS));

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_SLOTS: begin
               if (!cfg_ff.enabled && slots_ok) begin
                  cfg_in.max_slots = csr_wdata;
               end
            end
            CSR_ENABLED: begin
               cfg_in.enabled = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_slots <= MAX_SLOTS_RST;
         cfg_ff.enabled   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/connection_slot_table.sv
`default_nettype none

// Connection slot table. A beat on req_data is taken when start is high and busy is low; each
// request gives exactly one beat on rsp_data, marked by rsp_valid for one cycle, and the
// receiver cannot stall it. Requests rejected up front (not enabled, full by count, zero close
// identifier) answer in the cycle after acceptance. An open walks the active bits one slot per
// cycle; a close walks the identifier memory through its registered read port, one slot per
// cycle. busy stays high for the whole walk. Configuration writes are taken at any time;
// max_slots changes only while enabled is low.

module connection_slot_table
   import cst_pkg::*;
#(
   parameter int SLOTS   = 64,
   parameter int ID_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DEPTH = (SLOTS < MAX_SCAN) ? SLOTS : MAX_SCAN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (ID_BITS > CLOSE_ID_BITS) ? ID_BITS : CLOSE_ID_BITS;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_OPEN  = 3'b010,
      ST_CLOSE = 3'b100
   } state_type;

   cfg_type cfg;

   state_type                      state_ff, state_in;
   logic [CNT_BITS-1:0]            idx_ff, idx_in;
   logic [DEPTH-1:0]               active_ff, active_in;
   logic [CNT_BITS-1:0]            total_ff, total_in;
   logic [ID_BITS-1:0]             next_id_ff, next_id_in;
   logic [CLOSE_ID_BITS-1:0]       cid_ff, cid_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic [AW-1:0]                  rd_idx_ff;
   logic [ID_BITS-1:0]             rd_ident_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_type                        rsp_ff, rsp_in;

   logic [ID_BITS-1:0]             ident_mem [DEPTH];
   logic                           mem_we;
   logic                           issue;
   logic                           hit;
   logic [AW-1:0]                  addr;
   logic [CMP_W-1:0]               id_ext;

   cst_csr #(
      .SLOTS (SLOTS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign addr   = idx_ff[AW-1:0];
   assign id_ext = CMP_W'(next_id_ff);
   assign issue  = (state_ff == ST_CLOSE) && (idx_ff < cfg.max_slots);
   assign hit    = rd_vld_ff && active_ff[rd_idx_ff]
                   && (CMP_W'(rd_ident_ff) == CMP_W'(cid_ff));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      total_in     = total_ff;
      next_id_in   = next_id_ff;
      cid_in       = cid_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cid_in           = req_data.close_id;
               idx_in           = '0;
               rsp_in.opened_id = '0;
               if (!cfg.enabled) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_NOT_ENABLED;
               end else if (req_data.op == OP_OPEN) begin
                  if (total_ff >= cfg.max_slots) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     state_in = ST_OPEN;
                  end
               end else if (req_data.close_id == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_ZERO_ID;
               end else begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_OPEN: begin
            if (idx_ff >= cfg.max_slots) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = STATUS_FULL;
               rsp_in.opened_id = '0;
               state_in         = ST_IDLE;
            end else if (!active_ff[addr]) begin
               mem_we           = 1'b1;
               active_in[addr]  = 1'b1;
               next_id_in       = next_id_ff + ID_BITS'(1);
               total_in         = total_ff + CNT_BITS'(1);
               rsp_valid_in     = 1'b1;
               rsp_in.status    = STATUS_OK;
               rsp_in.opened_id = id_ext[OPENED_ID_BITS-1:0];
               state_in         = ST_IDLE;
            end else begin
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end
         ST_CLOSE: begin
            if (issue) begin
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + CNT_BITS'(1);
            end
            if (hit) begin
               active_in[rd_idx_ff] = 1'b0;
               if (total_ff != '0) begin
                  total_in = total_ff - CNT_BITS'(1);
               end
               rd_vld_in        = 1'b0;
               rsp_valid_in     = 1'b1;
               rsp_in.status    = STATUS_OK;
               rsp_in.opened_id = '0;
               state_in         = ST_IDLE;
            end else if (!rd_vld_ff && !issue) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = STATUS_NOT_FOUND;
               rsp_in.opened_id = '0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         rsp_in.active_count = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         active_ff    <= '0;
         total_ff     <= '0;
         next_id_ff   <= ID_BITS'(1);
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         total_ff     <= total_in;
         next_id_ff   <= next_id_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cid_ff <= cid_in;
      rsp_ff <= rsp_in;
   end

   // identifier store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ident_mem[addr] <= next_id_ff;
      end
      if (issue) begin
         rd_ident_ff <= ident_mem[addr];
         rd_idx_ff   <= addr;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(active_ff) == 32'(total_ff))
      else $error("active count out of step with active bits");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response beat while a scan is running");

   a_fail_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STATUS_OK)) |-> (rsp_ff.opened_id == '0))
      else $error("failed request returned an identifier");

   a_disabled_reject: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !cfg.enabled)
      |=> (rsp_valid_ff && (rsp_ff.status == STATUS_NOT_ENABLED)))
      else $error("request while disabled not rejected at once");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

endmodule

`default_nettype wire

>>> verif/connection_slot_table_tb.sv
module connection_slot_table_tb;
   import cst_pkg::*;

   localparam int TABLE_SLOTS = 64;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_data;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // shadow of the table
   logic                      slot_on [TABLE_SLOTS];
   logic [OPENED_ID_BITS-1:0] slot_id [TABLE_SLOTS];
   logic [CNT_BITS-1:0]       live_total;
   logic [OPENED_ID_BITS-1:0] next_id;
   logic [CNT_BITS-1:0]       slot_limit;
   logic                      run_on;
   logic [CLOSE_ID_BITS-1:0]  last_closed;

   rsp_type                   pending_rsp [$];
   rsp_type                   want;
   int unsigned               fail_count;
   int unsigned               gap_pct;

   connection_slot_table #(
      .SLOTS   (TABLE_SLOTS),
      .ID_BITS (32)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      #12_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void clear_table();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         slot_on[i] = 1'b0;
         slot_id[i] = '0;
      end
      live_total  = '0;
      next_id     = 32'd1;
      slot_limit  = CNT_BITS'(TABLE_SLOTS);
      run_on      = 1'b0;
      last_closed = 32'd1;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CSR_DATA_BITS-1:0] val);
      if (idx == CSR_MAX_SLOTS) begin
         if (!run_on && val >= 1 && val <= TABLE_SLOTS)
            slot_limit = val;
      end else if (idx == CSR_ENABLED) begin
         run_on = val[0];
      end
   endfunction

   function automatic rsp_type slot_request(req_type r);
      rsp_type o;
      int      hit;
      o   = '0;
      hit = -1;
      if (!run_on) begin
         o.status = STATUS_NOT_ENABLED;
      end else if (r.op == OP_OPEN) begin
         if (live_total >= slot_limit) begin
            o.status = STATUS_FULL;
         end else begin
            for (int i = 0; i < slot_limit; i++)
               if (hit < 0 && !slot_on[i])
                  hit = i;
            if (hit < 0) begin
               o.status = STATUS_FULL;
            end else begin
               slot_on[hit] = 1'b1;
               slot_id[hit] = next_id;
               o.status     = STATUS_OK;
               o.opened_id  = next_id;
               next_id      = next_id + 32'd1;
               live_total   = live_total + 1'b1;
            end
         end
      end else if (r.close_id == '0) begin
         o.status = STATUS_ZERO_ID;
      end else begin
         for (int i = 0; i < slot_limit; i++)
            if (hit < 0 && slot_on[i] && slot_id[i] == r.close_id)
               hit = i;
         if (hit < 0) begin
            o.status = STATUS_NOT_FOUND;
         end else begin
            slot_on[hit] = 1'b0;
            if (live_total > 0)
               live_total = live_total - 1'b1;
            last_closed = r.close_id;
            o.status    = STATUS_OK;
         end
      end
      o.active_count = live_total;
      return o;
   endfunction

   // one beat per request, held until busy is low at an edge
   task automatic send_req(logic op, logic [CLOSE_ID_BITS-1:0] id);
      req_type r;
      r.op       = op;
      r.close_id = id;
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_rsp.push_back(slot_request(r));
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_csr(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic test_disabled_requests();
      send_req(OP_OPEN, 32'h0);
      send_req(OP_CLOSE, 32'h0);
      send_req(OP_CLOSE, 32'd5);
      send_req(OP_CLOSE, 32'hFFFF_FFFF);
      drain();
      // out of range sizes are dropped, only bit 0 of enable counts
      csr_write(CSR_MAX_SLOTS, 7'd0);
      csr_write(CSR_MAX_SLOTS, 7'd65);
      csr_write(CSR_MAX_SLOTS, 7'd127);
      csr_write(CSR_ENABLED, 7'h7E);
      send_req(OP_OPEN, 32'hFFFF_FFFF);
   endtask

   task automatic test_open_close_basic();
      drain();
      csr_write(CSR_MAX_SLOTS, 7'd4);
      csr_write(CSR_ENABLED, 7'h03);
      repeat (5) send_req(OP_OPEN, 32'h0);
      send_req(OP_CLOSE, 32'd2);
      send_req(OP_CLOSE, 32'd0);
      send_req(OP_CLOSE, 32'd2);
      send_req(OP_CLOSE, 32'hFFFF_FFFF);
      send_req(OP_OPEN, 32'hFFFF_FFFF);
      send_req(OP_CLOSE, 32'd5);
      send_req(OP_CLOSE, 32'd1);
      send_req(OP_CLOSE, 32'd3);
      send_req(OP_CLOSE, 32'd4);
   endtask

   task automatic test_shrunk_window();
      drain();
      repeat (4) send_req(OP_OPEN, 32'h0);
      drain();
      csr_write(CSR_ENABLED, 7'h00);
      csr_write(CSR_MAX_SLOTS, 7'd2);
      csr_write(CSR_ENABLED, 7'h01);
      send_req(OP_CLOSE, 32'd9);
      send_req(OP_CLOSE, 32'd6);
      send_req(OP_OPEN, 32'h0);
      drain();
      // size write while running is dropped
      csr_write(CSR_MAX_SLOTS, 7'd40);
      send_req(OP_OPEN, 32'h0);
      drain();
      csr_write(CSR_ENABLED, 7'h00);
      csr_write(CSR_MAX_SLOTS, 7'd64);
      csr_write(CSR_ENABLED, 7'h01);
      send_req(OP_CLOSE, 32'd9);
   endtask

   task automatic run_traffic_block(int unsigned limit, int unsigned open_pct,
                                    int unsigned count);
      int          live_idx [$];
      int unsigned roll;
      logic [CLOSE_ID_BITS-1:0] id;
      drain();
      csr_write(CSR_ENABLED, {6'($urandom_range(63)), 1'b0});
      csr_write(CSR_MAX_SLOTS, CSR_DATA_BITS'(limit));
      csr_write(CSR_ENABLED, {6'($urandom_range(63)), 1'b1});
      csr_write(CSR_MAX_SLOTS, CSR_DATA_BITS'($urandom_range(127)));
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < open_pct) begin
            send_req(OP_OPEN, $urandom());
         end else begin
            roll = $urandom_range(99);
            live_idx.delete();
            for (int i = 0; i < TABLE_SLOTS; i++)
               if (slot_on[i])
                  live_idx.push_back(i);
            if (roll < 65 && live_idx.size() != 0)
               id = slot_id[live_idx[$urandom_range(live_idx.size() - 1)]];
            else if (roll < 80)
               id = last_closed;
            else if (roll < 92)
               id = $urandom();
            else
               id = '0;
            send_req(OP_CLOSE, id);
         end
      end
   endtask

   task automatic test_random_traffic(int unsigned pct);
      gap_pct = pct;
      run_traffic_block(1, 50, 30);
      run_traffic_block(3, 60, 40);
      run_traffic_block(64, 85, 90);
      run_traffic_block(9, 45, 40);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected beat: expected none actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t status: expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.opened_id !== want.opened_id) begin
               $display("%0t opened_id: expected %0d actual %0d",
                        $time, want.opened_id, rsp_data.opened_id);
               fail_count++;
            end
            if (rsp_data.active_count !== want.active_count) begin
               $display("%0t active_count: expected %0d actual %0d",
                        $time, want.active_count, rsp_data.active_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      gap_pct    = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_MAX_SLOTS;
      csr_wdata  = '0;
      clear_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_disabled_requests();
      test_open_close_basic();
      test_shrunk_window();
      test_random_traffic(32);
      test_random_traffic(67);
      test_random_traffic(0);
      drain();
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
